@@ src/spp_pkg.sv @@
// ----------------------------------------------------------------------------
// spp_pkg: shared types and constants
// Entry layout, sizes and flag bits for the sweep-and-prune pair unit.
// ----------------------------------------------------------------------------
package spp_pkg;

   localparam int MAX_ACTIVE  = 32;
   localparam int COORD_WIDTH = 24;
   localparam int ID_W        = 10;
   localparam int RAD_W       = COORD_WIDTH - 1;
   localparam int FLAG_W      = 5;
   localparam int SLOT_W      = $clog2(MAX_ACTIVE);
   localparam int CNT_W       = $clog2(MAX_ACTIVE + 1);

   localparam logic [FLAG_W-1:0] F_BAD  = 5'b00001;
   localparam logic [FLAG_W-1:0] F_PART = 5'b00010;
   localparam logic [FLAG_W-1:0] F_NOC2 = 5'b00100;
   localparam logic [FLAG_W-1:0] F_PROJ = 5'b01000;
   localparam logic [FLAG_W-1:0] F_NOPC = 5'b10000;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOT_ACT = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]               id;
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
      logic [RAD_W-1:0]              radius;
      logic [FLAG_W-1:0]             flags;
   } entry_type;

endpackage

@@ src/spp_cell.sv @@
// ----------------------------------------------------------------------------
// spp_cell: one slot of the active ring
// Holds one entry; shifts towards the head or loads new data.
// ----------------------------------------------------------------------------
module spp_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  spp_pkg::entry_type shift_data,
   input  logic               load_en,
   input  spp_pkg::entry_type load_data,
   output spp_pkg::entry_type entry_ff
);

   spp_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (shift_en) begin
         entry_in = shift_data;
      end else if (load_en) begin
         entry_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ src/spp_pair_cmp.sv @@
// ----------------------------------------------------------------------------
// spp_pair_cmp: sphere overlap pipeline
// Box prefilter, then squares, then the distance compare (combinational out).
// ----------------------------------------------------------------------------
module spp_pair_cmp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [spp_pkg::COORD_WIDTH-1:0] new_x,
   input  logic signed [spp_pkg::COORD_WIDTH-1:0] new_y,
   input  logic signed [spp_pkg::COORD_WIDTH-1:0] new_z,
   input  logic [spp_pkg::RAD_W-1:0]              new_r,
   input  spp_pkg::entry_type                     entry,
   output logic                                  hit,
   output logic [spp_pkg::ID_W-1:0]               hit_id
);

   localparam int CW = spp_pkg::COORD_WIDTH;

   logic signed [CW:0] ddx, ddy, ddz;
   logic [CW:0]        adx, ady, adz;
   logic [CW-1:0]      rs;
   logic               near;

   logic                     a_valid_ff;
   logic [CW-1:0]            a_dx_ff, a_dy_ff, a_dz_ff, a_rs_ff;
   logic [spp_pkg::ID_W-1:0] a_id_ff;

   logic                     b_valid_ff;
   logic [2*CW-1:0]          b_sx_ff, b_sy_ff, b_sz_ff, b_rr_ff;
   logic [spp_pkg::ID_W-1:0] b_id_ff;

   logic [2*CW+1:0]          dist2;

   always_comb begin
      ddx  = {new_x[CW-1], new_x} - {entry.x[CW-1], entry.x};
      ddy  = {new_y[CW-1], new_y} - {entry.y[CW-1], entry.y};
      ddz  = {new_z[CW-1], new_z} - {entry.z[CW-1], entry.z};
      adx  = ddx[CW] ? (CW+1)'(-ddx) : ddx;
      ady  = ddy[CW] ? (CW+1)'(-ddy) : ddy;
      adz  = ddz[CW] ? (CW+1)'(-ddz) : ddz;
      rs   = {1'b0, new_r} + {1'b0, entry.radius};
      near = (ady <= {1'b0, rs}) && (adx <= {1'b0, rs}) && (adz <= {1'b0, rs});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid && near;
         b_valid_ff <= a_valid_ff;
      end
   end

   // past the box test every difference is at most the radius sum
   always_ff @(posedge clock) begin
      a_dx_ff <= adx[CW-1:0];
      a_dy_ff <= ady[CW-1:0];
      a_dz_ff <= adz[CW-1:0];
      a_rs_ff <= rs;
      a_id_ff <= entry.id;
      b_sx_ff <= a_dx_ff * a_dx_ff;
      b_sy_ff <= a_dy_ff * a_dy_ff;
      b_sz_ff <= a_dz_ff * a_dz_ff;
      b_rr_ff <= a_rs_ff * a_rs_ff;
      b_id_ff <= a_id_ff;
   end

   assign dist2  = {2'b00, b_sx_ff} + {2'b00, b_sy_ff} + {2'b00, b_sz_ff};
   assign hit    = b_valid_ff && (dist2 < {2'b00, b_rr_ff});
   assign hit_id = b_id_ff;

endmodule

@@ src/sweep_prune_sphere_pairs_unit.sv @@
// ----------------------------------------------------------------------------
// sweep_prune_sphere_pairs_unit: sweep-and-prune broad phase for spheres
// Every item passes the sweep, drain and finish states: the active ring
// rotates once (one compare per cycle), the drain state empties the compare
// pipeline, and the finish state updates the ring and emits the status. A pair
// passes the two compare stages and the response registers after its compare.
// A new item is taken only when idle. Synchronous reset empties the set; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module sweep_prune_sphere_pairs_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_kind,
   input  logic [spp_pkg::ID_W-1:0]               req_object_id,
   input  logic signed [spp_pkg::COORD_WIDTH-1:0] req_center_x,
   input  logic signed [spp_pkg::COORD_WIDTH-1:0] req_center_y,
   input  logic signed [spp_pkg::COORD_WIDTH-1:0] req_center_z,
   input  logic [spp_pkg::RAD_W-1:0]              req_sphere_radius,
   input  logic [spp_pkg::FLAG_W-1:0]             req_object_flags,
   output logic                                  rsp_strobe,
   output logic                                  rsp_pair_valid,
   output logic [spp_pkg::ID_W-1:0]               rsp_entering_id,
   output logic [spp_pkg::ID_W-1:0]               rsp_partner_id,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_last
);

   localparam int N = spp_pkg::MAX_ACTIVE;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SWEEP = 4'b0010,
      S_DRAIN = 4'b0100,
      S_FIN   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [spp_pkg::SLOT_W-1:0] step_ff, step_in;
   logic                       drain_ff, drain_in;
   logic [spp_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       found_ff, found_in;
   logic [spp_pkg::SLOT_W-1:0] cur_ff, cur_in;
   spp_pkg::entry_type         req_ff, last_ff, last_in;
   logic                       kind_ff;

   spp_pkg::entry_type cells [N];
   logic               load_en [N];
   spp_pkg::entry_type load_data;
   logic               shift_en, head_valid, head_match, cmp_valid;
   logic [spp_pkg::FLAG_W-1:0] skipm;
   logic [spp_pkg::SLOT_W-1:0] load_slot;
   logic               do_load;
   logic [1:0]         fin_status;
   logic               cmp_hit;
   logic [spp_pkg::ID_W-1:0] cmp_id;

   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic                     rsp_pair_ff, rsp_pair_in, rsp_last_ff, rsp_last_in;
   logic [spp_pkg::ID_W-1:0] rsp_pid_ff, rsp_pid_in;
   logic [spp_pkg::ID_W-1:0] rsp_eid_ff, rsp_eid_in;
   logic [1:0]               rsp_st_ff, rsp_st_in;

   assign busy     = (state_ff != S_IDLE);
   assign shift_en = (state_ff == S_SWEEP);

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_ring
         spp_cell u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .shift_data (cells[(g + 1) % N]),
            .load_en    (load_en[g]),
            .load_data  (load_data),
            .entry_ff   (cells[g])
         );
         assign load_en[g] = do_load && (load_slot == spp_pkg::SLOT_W'(g));
      end
   endgenerate

   // cells[0] holds slot step_ff while sweeping
   always_comb begin
      head_valid = shift_en && ({1'b0, step_ff} < cnt_ff);
      head_match = head_valid && (cells[0].id == req_ff.id);
      skipm = spp_pkg::F_BAD
            | (req_ff.flags & spp_pkg::F_PART)
            | (req_ff.flags & spp_pkg::F_NOC2)
            | (((req_ff.flags & spp_pkg::F_PROJ) != '0) &&
               ((req_ff.flags & spp_pkg::F_NOPC) != '0) ? spp_pkg::F_PROJ : '0);
      cmp_valid = head_valid && !head_match && !kind_ff
               && ((cells[0].flags & skipm) == '0);
   end

   spp_pair_cmp u_cmp (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cmp_valid),
      .new_x    (req_ff.x),
      .new_y    (req_ff.y),
      .new_z    (req_ff.z),
      .new_r    (req_ff.radius),
      .entry    (cells[0]),
      .hit      (cmp_hit),
      .hit_id   (cmp_id)
   );

   // ring update and status at the end of the item
   always_comb begin
      do_load    = 1'b0;
      load_slot  = cur_ff;
      load_data  = req_ff;
      fin_status = spp_pkg::ST_OK;
      cnt_in     = cnt_ff;
      if (state_ff == S_FIN) begin
         if (!kind_ff) begin
            if (found_ff) begin
               do_load = 1'b1;
            end else if (cnt_ff < spp_pkg::CNT_W'(N)) begin
               do_load   = 1'b1;
               load_slot = cnt_ff[spp_pkg::SLOT_W-1:0];
               cnt_in    = cnt_ff + 1'b1;
            end else begin
               fin_status = spp_pkg::ST_FULL;
            end
         end else begin
            load_data = last_ff;
            if (found_ff) begin
               do_load = 1'b1;
               cnt_in  = cnt_ff - 1'b1;
            end else begin
               fin_status = spp_pkg::ST_NOT_ACT;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      drain_in = drain_ff;
      found_in = found_ff;
      cur_in   = cur_ff;
      last_in  = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SWEEP;
               step_in  = '0;
               found_in = 1'b0;
            end
         end
         S_SWEEP: begin
            if (head_match) begin
               found_in = 1'b1;
               cur_in   = step_ff;
            end
            if ({1'b0, step_ff} == cnt_ff - 1'b1) begin
               last_in = cells[0];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == spp_pkg::SLOT_W'(N - 1)) begin
               state_in = S_DRAIN;
               drain_in = 1'b0;
            end
         end
         S_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // entering id is registered: a new item may be taken while the status is out
   always_comb begin
      rsp_strobe_in = cmp_hit || (state_ff == S_FIN);
      rsp_pair_in   = cmp_hit;
      rsp_pid_in    = cmp_hit ? cmp_id : '0;
      rsp_eid_in    = req_ff.id;
      rsp_st_in     = cmp_hit ? spp_pkg::ST_OK : fin_status;
      rsp_last_in   = !cmp_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      drain_ff    <= drain_in;
      found_ff    <= found_in;
      cur_ff      <= cur_in;
      last_ff     <= last_in;
      rsp_pair_ff <= rsp_pair_in;
      rsp_pid_ff  <= rsp_pid_in;
      rsp_eid_ff  <= rsp_eid_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == S_IDLE && start) begin
         kind_ff <= req_kind;
         req_ff  <= '{id: req_object_id, x: req_center_x, y: req_center_y,
                      z: req_center_z, radius: req_sphere_radius,
                      flags: req_object_flags};
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_pair_valid  = rsp_pair_ff;
   assign rsp_entering_id = rsp_eid_ff;
   assign rsp_partner_id  = rsp_pid_ff;
   assign rsp_status      = rsp_st_ff;
   assign rsp_last        = rsp_last_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= spp_pkg::CNT_W'(N))
      else $error("active count beyond capacity");

   a_no_hit_in_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> !cmp_hit)
      else $error("pair hit collides with status");

   a_last_after_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |=> (rsp_strobe && rsp_last && !busy))
      else $error("status item missing after finish");

endmodule

@@ tb/tb_sweep_prune_sphere_pairs_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sweep_prune_sphere_pairs_unit: broad-phase pair unit testbench
// Feeds enter/leave edge items through the start/busy handshake, predicts the
// pair and status results from a shadow copy of the active set and checks
// each strobed result in order against the predicted list.
// ----------------------------------------------------------------------------
module tb_sweep_prune_sphere_pairs_unit;

   localparam int KIND_ENTER = 0;
   localparam int KIND_LEAVE = 1;
   localparam int NUM_IDS    = 1024;

   typedef struct {
      logic                                   kind;
      logic [spp_pkg::ID_W-1:0]               id;
      logic signed [spp_pkg::COORD_WIDTH-1:0] x, y, z;
      logic [spp_pkg::RAD_W-1:0]              radius;
      logic [spp_pkg::FLAG_W-1:0]             flags;
   } edge_item_type;

   typedef struct {
      logic                     pair_valid;
      logic [spp_pkg::ID_W-1:0] entering_id;
      logic [spp_pkg::ID_W-1:0] partner_id;
      logic [1:0]               status;
      logic                     last;
   } contact_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_kind = 0;
   logic [spp_pkg::ID_W-1:0] req_object_id = '0;
   logic signed [spp_pkg::COORD_WIDTH-1:0] req_center_x = '0, req_center_y = '0;
   logic signed [spp_pkg::COORD_WIDTH-1:0] req_center_z = '0;
   logic [spp_pkg::RAD_W-1:0] req_sphere_radius = '0;
   logic [spp_pkg::FLAG_W-1:0] req_object_flags = '0;
   logic rsp_strobe, rsp_pair_valid, rsp_last;
   logic [spp_pkg::ID_W-1:0] rsp_entering_id, rsp_partner_id;
   logic [1:0] rsp_status;

   sweep_prune_sphere_pairs_unit uut (.*);

   always #5 clock = ~clock;

   edge_item_type pending_edges[$];
   contact_type   expected_contacts[$];
   int            error_count = 0;
   bit            calm = 0;

   // shadow of the active set
   spp_pkg::entry_type sweep_set[spp_pkg::MAX_ACTIVE];
   int                 sweep_count = 0;
   int                 slot_map[NUM_IDS];
   // ids currently active, for stimulus
   int                 live_ids[$];

   task automatic report_mismatch(input string what);
      $display("MISMATCH t=%0t: %s", $time, what);
      error_count++;
   endtask

   function automatic logic [63:0] abs_diff(
         input logic signed [spp_pkg::COORD_WIDTH-1:0] a,
         input logic signed [spp_pkg::COORD_WIDTH-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d < 0 ? -d : d;
   endfunction

   task automatic predict_contacts(input edge_item_type e);
      int cur;
      int last_slot;
      logic [spp_pkg::FLAG_W-1:0] skip;
      logic [63:0] rs, dx, dy, dz;
      logic [1:0] st;
      contact_type c;
      cur = -1;
      if (slot_map[e.id] < sweep_count && sweep_set[slot_map[e.id]].id == e.id)
         cur = slot_map[e.id];
      if (e.kind == KIND_ENTER) begin
         skip = spp_pkg::F_BAD;
         if (e.flags & spp_pkg::F_PART) skip |= spp_pkg::F_PART;
         if (e.flags & spp_pkg::F_NOC2) skip |= spp_pkg::F_NOC2;
         if ((e.flags & spp_pkg::F_PROJ) && (e.flags & spp_pkg::F_NOPC))
            skip |= spp_pkg::F_PROJ;
         for (int k = 0; k < sweep_count; k++) begin
            if (k == cur || (sweep_set[k].flags & skip) != 0) continue;
            rs = 64'(e.radius) + 64'(sweep_set[k].radius);
            dx = abs_diff(e.x, sweep_set[k].x);
            dy = abs_diff(e.y, sweep_set[k].y);
            dz = abs_diff(e.z, sweep_set[k].z);
            if (dy > rs || dx > rs || dz > rs) continue;
            if (dx * dx + dy * dy + dz * dz < rs * rs) begin
               c = '{1'b1, e.id, sweep_set[k].id, spp_pkg::ST_OK, 1'b0};
               expected_contacts = {expected_contacts, c};
            end
         end
         st = spp_pkg::ST_OK;
         if (cur < 0) begin
            if (sweep_count >= spp_pkg::MAX_ACTIVE) st = spp_pkg::ST_FULL;
            else begin
               cur = sweep_count++;
               slot_map[e.id] = cur;
            end
         end
         if (st == spp_pkg::ST_OK)
            sweep_set[cur] = '{e.id, e.x, e.y, e.z, e.radius, e.flags};
      end else begin
         st = spp_pkg::ST_OK;
         if (cur < 0) st = spp_pkg::ST_NOT_ACT;
         else begin
            last_slot = sweep_count - 1;
            if (cur != last_slot) begin
               sweep_set[cur] = sweep_set[last_slot];
               slot_map[sweep_set[cur].id] = cur;
            end
            slot_map[e.id] = 'h3F;
            sweep_count = last_slot;
         end
      end
      c = '{1'b0, e.id, '0, st, 1'b1};
      expected_contacts = {expected_contacts, c};
   endtask

   // driver
   always @(posedge clock) begin
      edge_item_type e;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) predict_contacts(pending_edges.pop_front());
         // an item that is waiting stays on the ports
         if (!(start && busy)) begin
            if (pending_edges.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
               e = pending_edges[0];
               start <= 1'b1;
               req_kind <= e.kind;
               req_object_id <= e.id;
               req_center_x <= e.x;
               req_center_y <= e.y;
               req_center_z <= e.z;
               req_sphere_radius <= e.radius;
               req_object_flags <= e.flags;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         contact_type w;
         if (expected_contacts.size() == 0)
            report_mismatch($sformatf("unexpected result, entering %0d", rsp_entering_id));
         else begin
            w = expected_contacts.pop_front();
            if (rsp_pair_valid !== w.pair_valid || rsp_entering_id !== w.entering_id ||
                rsp_partner_id !== w.partner_id || rsp_status !== w.status ||
                rsp_last !== w.last)
               report_mismatch($sformatf(
                  "got v%b e%0d p%0d s%0d l%b, want v%b e%0d p%0d s%0d l%b",
                  rsp_pair_valid, rsp_entering_id, rsp_partner_id, rsp_status, rsp_last,
                  w.pair_valid, w.entering_id, w.partner_id, w.status, w.last));
         end
      end
   end

   function automatic edge_item_type make_enter(input int id, input int x, input int y,
                                                input int z, input int r, input int fl);
      edge_item_type e;
      e.kind = 1'(KIND_ENTER);
      e.id = spp_pkg::ID_W'(id);
      e.x = spp_pkg::COORD_WIDTH'(x);
      e.y = spp_pkg::COORD_WIDTH'(y);
      e.z = spp_pkg::COORD_WIDTH'(z);
      e.radius = spp_pkg::RAD_W'(r);
      e.flags = spp_pkg::FLAG_W'(fl);
      return e;
   endfunction

   function automatic edge_item_type make_leave(input int id);
      edge_item_type e;
      e = make_enter(id, $urandom, $urandom, $urandom, $urandom_range(1, 'h7FFFFF), $urandom);
      e.kind = 1'(KIND_LEAVE);
      return e;
   endfunction

   // clustered centres so that pairs are frequent
   function automatic edge_item_type random_enter(input int id);
      int span;
      span = $urandom_range(3) == 0 ? 'h7FFFFF : 4000;
      if ($urandom_range(9) == 0)
         return make_enter(id, $urandom, $urandom, $urandom,
                           $urandom_range(1, 'h7FFFFF), $urandom);
      return make_enter(id, $urandom_range(0, 2 * span) - span,
                        $urandom_range(0, 2 * span) - span,
                        $urandom_range(0, 2 * span) - span,
                        $urandom_range(1, 2500),
                        $urandom_range(4) == 0 ? $urandom_range(31) : 0);
   endfunction

   task automatic queue_edge(input edge_item_type e);
      int idx[$];
      pending_edges = {pending_edges, e};
      idx = live_ids.find_first_index(v) with (v == e.id);
      if (e.kind == KIND_ENTER) begin
         if (idx.size() == 0 && live_ids.size() < spp_pkg::MAX_ACTIVE)
            live_ids = {live_ids, int'(e.id)};
      end else if (idx.size() > 0) live_ids.delete(idx[0]);
   endtask

   initial begin
      int id;
      for (int i = 0; i < NUM_IDS; i++) slot_map[i] = 'h3F;
      // directed: extremes, every flag, overlap, re-enter, unknown leave
      queue_edge(make_enter(0, 0, 0, 0, 1, 0));
      queue_edge(make_enter(1023, 1, 0, 0, 1, 0));
      queue_edge(make_enter(5, -8388608, -8388608, -8388608, 'h7FFFFF, 0));
      queue_edge(make_enter(6, 8388607, 8388607, 8388607, 'h7FFFFF, 0));
      queue_edge(make_enter(7, 0, 2, 0, 1, 0));
      queue_edge(make_enter(8, 0, 0, 0, 5, spp_pkg::F_BAD));
      queue_edge(make_enter(9, 0, 0, 0, 5, spp_pkg::F_PART));
      queue_edge(make_enter(10, 0, 0, 0, 5, spp_pkg::F_PART));
      queue_edge(make_enter(11, 0, 0, 0, 5, spp_pkg::F_NOC2));
      queue_edge(make_enter(12, 0, 0, 0, 5, spp_pkg::F_NOC2));
      queue_edge(make_enter(13, 0, 0, 0, 5, spp_pkg::F_PROJ));
      queue_edge(make_enter(14, 0, 0, 0, 5, spp_pkg::F_PROJ | spp_pkg::F_NOPC));
      queue_edge(make_enter(0, 3, 0, 0, 4, 5'h1F));
      queue_edge(make_leave(500));
      queue_edge(make_leave(7));
      queue_edge(make_leave(0));
      for (int i = 0; i < 24; i++) queue_edge(make_enter(100 + i, i, 0, 0, 1, 0));
      queue_edge(make_enter(200, 0, 0, 0, 1, 0));
      queue_edge(make_leave(1023));
      // random: mostly enters and leaves of live objects
      for (int i = 0; i < 280; i++) begin
         if (live_ids.size() > 0 && $urandom_range(99) < 45)
            queue_edge(make_leave(live_ids[$urandom_range(live_ids.size() - 1)]));
         else if (live_ids.size() > 0 && $urandom_range(99) < 8)
            queue_edge(random_enter(live_ids[$urandom_range(live_ids.size() - 1)]));
         else begin
            id = $urandom_range(1023);
            if ($urandom_range(99) < 6) queue_edge(make_leave(id));
            else queue_edge(random_enter(id));
         end
      end
      repeat (7) @(posedge clock);
      reset <= 0;
      fork
         begin
            repeat (3000) @(posedge clock);
            calm = 1;
            repeat (3000) @(posedge clock);
            calm = 0;
         end
      join_none
      wait (pending_edges.size() == 0 && expected_contacts.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0) $display("** sweep_prune_sphere_pairs_unit: PASSED **");
      else $display("** sweep_prune_sphere_pairs_unit: FAILED **");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** sweep_prune_sphere_pairs_unit: FAILED **");
      $finish;
   end

endmodule
